// ===== src/ptwa_pkg.sv =====
// ============================================================================
// ptwa_pkg: shared types and constants of the peer table with aging
// Field widths, operation and status codes, and the probe beat that walks the
// slot chain.
// ============================================================================
package ptwa_pkg;

   localparam int TABLE_SIZE_DEF = 16;

   // Field widths.
   localparam int OP_W     = 2;
   localparam int ID_W     = 32;
   localparam int NOW_W    = 40;
   localparam int IDX_W    = 4;
   localparam int TMO_W    = 32;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 5;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W   = 80;
   localparam int RSP_FIELDS_W = STATUS_W + CNT_W + CNT_W + 1 + ID_W + NOW_W;
   localparam int RSP_DATA_W   = 88;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_ID    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_VALID = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = 2'd2;
   localparam logic [TMO_W-1:0]     TIMEOUT_RESET  = 32'd30000;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ANNOUNCE = 2'd0;
   localparam logic [OP_W-1:0] OP_EXPIRE   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ     = 2'd2;

   // Announce status codes.
   localparam logic [STATUS_W-1:0] STS_IGNORED   = 2'd0;
   localparam logic [STATUS_W-1:0] STS_REFRESHED = 2'd1;
   localparam logic [STATUS_W-1:0] STS_ADDED     = 2'd2;
   localparam logic [STATUS_W-1:0] STS_DROPPED   = 2'd3;

   // Probe that moves one slot down the chain per cycle.
   typedef struct packed {
      logic             valid;
      logic             age;     // 1: aging check, 0: id search
      logic             found;   // an earlier slot already matched the key
      logic [ID_W-1:0]  key;
      logic [NOW_W-1:0] now;
      logic [TMO_W-1:0] timeout;
   } probe_type;

   // Write strobes from the controller into one slot.
   typedef struct packed {
      logic id_en;
      logic seen_en;
      logic old_en;
   } wr_type;

endpackage

// ===== src/ptwa_slot.sv =====
// ============================================================================
// ptwa_slot: one table slot of the peer chain
// Holds one peer id, its last-seen time and its expiry flag, and passes the
// probe on to the next slot after checking it against the local entry.
// ============================================================================
module ptwa_slot #(
   parameter int TABLE_SIZE = ptwa_pkg::TABLE_SIZE_DEF,
   parameter int SLOT_IDX   = 0
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  ptwa_pkg::probe_type                                  probe_i,
   input  logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] hit_idx_i,
   input  logic [$clog2(TABLE_SIZE + 1)-1:0]                    fill_i,
   output ptwa_pkg::probe_type                                  probe_o,
   output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] hit_idx_o,
   input  ptwa_pkg::wr_type                                     wr_i,
   input  logic [ptwa_pkg::ID_W-1:0]                            wr_id_i,
   input  logic [ptwa_pkg::NOW_W-1:0]                           wr_seen_i,
   input  logic                                                 wr_old_i,
   output logic [ptwa_pkg::ID_W-1:0]                            id_o,
   output logic [ptwa_pkg::NOW_W-1:0]                           seen_o,
   output logic                                                 old_o
);

   localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int FW = $clog2(TABLE_SIZE + 1);
   localparam int NW = ptwa_pkg::NOW_W;
   localparam int TW = ptwa_pkg::TMO_W;

   ptwa_pkg::probe_type        probe_ff, probe_in;
   logic [IW-1:0]              hit_idx_ff, hit_idx_in;
   logic [ptwa_pkg::ID_W-1:0]  id_ff;
   logic [NW-1:0]              seen_ff;
   logic                       old_ff, old_in;
   logic                       live, match;
   logic [NW:0]                age_diff;

   // The slot holds a table entry only while its position is below the count.
   assign live  = (FW'(SLOT_IDX) < fill_i);
   assign match = probe_i.valid && !probe_i.age && !probe_i.found && live &&
                  (id_ff == probe_i.key);

   // The top bit of the difference is set when time ran backwards.
   assign age_diff = {1'b0, probe_i.now} - {1'b0, seen_ff};

   always_comb begin
      probe_in   = probe_i;
      hit_idx_in = hit_idx_i;
      old_in     = old_ff;
      if (match) begin
         probe_in.found = 1'b1;
         hit_idx_in     = IW'(SLOT_IDX);
      end
      if (wr_i.old_en) begin
         old_in = wr_old_i;
      end else if (probe_i.valid && probe_i.age) begin
         old_in = !age_diff[NW] && (age_diff[NW-1:0] > {{(NW-TW){1'b0}}, probe_i.timeout});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
      hit_idx_ff <= hit_idx_in;
      old_ff     <= old_in;
      if (wr_i.id_en) begin
         id_ff <= wr_id_i;
      end
      if (wr_i.seen_en) begin
         seen_ff <= wr_seen_i;
      end
   end

   assign probe_o   = probe_ff;
   assign hit_idx_o = hit_idx_ff;
   assign id_o      = id_ff;
   assign seen_o    = seen_ff;
   assign old_o     = old_ff;

endmodule

// ===== src/peer_table_with_aging.sv =====
// ============================================================================
// peer_table_with_aging: dense peer table with timeout aging
// A chain of table slots with a probe that walks it, plus the controller that
// appends, refreshes, compacts and reads entries.
// ============================================================================
// Usage:
//   Request beats arrive on req_*; tuser carries the opcode (announce, expire
//   sweep, read entry) and tdata the peer id, the current time and the read
//   index. Every request gives exactly one response beat on rsp_*, carrying
//   the announce status, the number of expired entries, the peer count after
//   the request and, for a read, the stored entry.
//   Announce and expire send a probe down the slot chain, one slot per cycle;
//   an expire sweep then compacts the table, one step per cycle, until the
//   front pointer meets the peer count. A read or an own-id announce skips
//   the probe and goes straight to the response. One request is in work at
//   a time; req_tready is high while the controller is idle.
//   The response sits in an output register, so a new request is accepted
//   while rsp_tvalid waits for rsp_tready; a finished request whose response
//   cannot be loaded yet holds the controller until the register frees up.
//   Reset (synchronous, active high) empties the table and restores the
//   configuration registers; the slot contents are not cleared.
//   Configuration writes on csr_* take effect at once and belong in idle time.
// ============================================================================
module peer_table_with_aging #(
   parameter int TABLE_SIZE = ptwa_pkg::TABLE_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata from bit 0: peer_id[31:0], now_ms[71:32], entry_index[75:72], zero pad
   input  logic [ptwa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: opcode[1:0]
   input  logic [ptwa_pkg::OP_W-1:0]          req_tuser,
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata from bit 0: announce_status[1:0], expired_count[6:2], peer_total[11:7],
   // entry_valid[12], entry_id[44:13], entry_seen_ms[84:45], zero pad
   output logic [ptwa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Configuration write port.
   input  logic                               csr_we,
   input  logic [ptwa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptwa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int FW  = $clog2(TABLE_SIZE + 1);
   localparam int CW  = ptwa_pkg::CNT_W;
   localparam int DW  = ptwa_pkg::ID_W;
   localparam int NW  = ptwa_pkg::NOW_W;
   localparam int XW  = ptwa_pkg::IDX_W;
   localparam int TW  = ptwa_pkg::TMO_W;
   localparam int PW  = ptwa_pkg::RSP_PAD_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_PROBE,
      ST_COMPACT,
      ST_DONE
   } state_type;

   state_type                        state_ff;
   logic [ptwa_pkg::OP_W-1:0]        op_ff;
   logic [DW-1:0]                    key_ff;
   logic [NW-1:0]                    now_ff;
   logic [XW-1:0]                    idx_ff;
   logic [ptwa_pkg::STATUS_W-1:0]    status_ff;
   logic [FW-1:0]                    expired_ff;
   logic [FW-1:0]                    front_ff;
   logic [FW-1:0]                    fill_ff;
   logic [DW-1:0]                    self_id_ff;
   logic                             self_valid_ff;
   logic [TW-1:0]                    timeout_ff;
   logic                             rsp_valid_ff;
   logic [ptwa_pkg::RSP_DATA_W-1:0]  rsp_data_ff;

   // Slot chain wiring: element 0 is the launch point, the last is the tail.
   ptwa_pkg::probe_type  chain_probe [TABLE_SIZE+1];
   logic [IW-1:0]        chain_hit   [TABLE_SIZE+1];
   ptwa_pkg::wr_type     slot_wr     [TABLE_SIZE];
   logic [DW-1:0]        slot_id     [TABLE_SIZE];
   logic [NW-1:0]        slot_seen   [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] old_vec;

   ptwa_pkg::probe_type  tail_probe;
   logic [IW-1:0]        tail_hit;
   logic                 req_fire;
   logic                 tail_done;
   logic                 rsp_load;
   logic                 add_en, refresh_en, copy_en;
   logic                 front_old;
   logic [FW-1:0]        fill_last;
   logic [IW-1:0]        rd_addr;
   logic [DW-1:0]        rd_id;
   logic [NW-1:0]        rd_seen;
   logic                 rd_old;
   logic                 rd_hit;
   logic [DW-1:0]        wr_id;
   logic [NW-1:0]        wr_seen;
   logic [DW-1:0]        req_id;
   logic [NW-1:0]        req_now;
   logic [XW-1:0]        req_idx;

   assign req_id  = req_tdata[DW-1:0];
   assign req_now = req_tdata[DW +: NW];
   assign req_idx = req_tdata[DW+NW +: XW];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // A finished request moves into the response register once that register
   // is empty or is being emptied in the same cycle.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // A probe enters the chain for exactly one cycle per sweep and per announce of an id other than the own one.
   always_comb begin
      chain_probe[0]         = '0;
      chain_probe[0].valid   = (state_ff == ST_LAUNCH);
      chain_probe[0].age     = (op_ff == ptwa_pkg::OP_EXPIRE);
      chain_probe[0].found   = 1'b0;
      chain_probe[0].key     = key_ff;
      chain_probe[0].now     = now_ff;
      chain_probe[0].timeout = timeout_ff;
      chain_hit[0]           = '0;
   end

   assign tail_probe = chain_probe[TABLE_SIZE];
   assign tail_hit   = chain_hit[TABLE_SIZE];
   assign tail_done  = (state_ff == ST_PROBE) && tail_probe.valid;

   // The single read port of the chain: during compaction it fetches the
   // last entry, otherwise it serves the read request.
   assign fill_last = fill_ff - FW'(1);
   assign rd_addr   = (state_ff == ST_COMPACT) ? fill_last[IW-1:0] : IW'(idx_ff);
   assign rd_id     = slot_id[rd_addr];
   assign rd_seen   = slot_seen[rd_addr];
   assign rd_old    = old_vec[rd_addr];
   assign rd_hit    = (op_ff == ptwa_pkg::OP_READ) &&
                      ({{FW{1'b0}}, idx_ff} < {{XW{1'b0}}, fill_ff});

   // An announce that found no match appends at the count if there is room; one that matched
   // refreshes the time of the matching slot.
   assign add_en     = tail_done && (op_ff != ptwa_pkg::OP_EXPIRE) && !tail_probe.found &&
                       (fill_ff < FW'(TABLE_SIZE));
   assign refresh_en = tail_done && (op_ff != ptwa_pkg::OP_EXPIRE) && tail_probe.found;

   // Compaction: an expired entry at the front pointer is replaced by the last
   // entry, whose own expiry flag travels with it so the slot is rechecked.
   // When the expired entry is itself the last one it is only dropped.
   assign front_old = (front_ff != fill_ff) && old_vec[front_ff[IW-1:0]];
   assign copy_en   = (state_ff == ST_COMPACT) && front_old && (front_ff != fill_last);

   assign wr_id   = copy_en ? rd_id   : key_ff;
   assign wr_seen = copy_en ? rd_seen : now_ff;

   for (genvar j = 0; j < TABLE_SIZE; j++) begin : g_slot
      always_comb begin
         slot_wr[j].id_en   = (add_en && (fill_ff == FW'(j))) ||
                              (copy_en && (front_ff == FW'(j)));
         slot_wr[j].seen_en = slot_wr[j].id_en || (refresh_en && (tail_hit == IW'(j)));
         slot_wr[j].old_en  = copy_en && (front_ff == FW'(j));
      end

      ptwa_slot #(
         .TABLE_SIZE (TABLE_SIZE),
         .SLOT_IDX   (j)
      ) u_slot (
         .clock     (clock),
         .reset     (reset),
         .probe_i   (chain_probe[j]),
         .hit_idx_i (chain_hit[j]),
         .fill_i    (fill_ff),
         .probe_o   (chain_probe[j+1]),
         .hit_idx_o (chain_hit[j+1]),
         .wr_i      (slot_wr[j]),
         .wr_id_i   (wr_id),
         .wr_seen_i (wr_seen),
         .wr_old_i  (rd_old),
         .id_o      (slot_id[j]),
         .seen_o    (slot_seen[j]),
         .old_o     (old_vec[j])
      );
   end

   // Controller, configuration registers and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         self_id_ff    <= '0;
         self_valid_ff <= 1'b0;
         timeout_ff    <= ptwa_pkg::TIMEOUT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ptwa_pkg::CSR_SELF_ID: begin
                  self_id_ff <= csr_wdata[DW-1:0];
               end
               ptwa_pkg::CSR_SELF_VALID: begin
                  self_valid_ff <= csr_wdata[0];
               end
               ptwa_pkg::CSR_TIMEOUT: begin
                  timeout_ff <= csr_wdata[TW-1:0];
               end
               default: begin
               end
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff      <= req_tuser;
                  key_ff     <= req_id;
                  now_ff     <= req_now;
                  idx_ff     <= req_idx;
                  status_ff  <= ptwa_pkg::STS_IGNORED;
                  expired_ff <= '0;
                  front_ff   <= '0;
                  case (req_tuser)
                     ptwa_pkg::OP_ANNOUNCE: begin
                        if (self_valid_ff && (req_id == self_id_ff)) begin
                           state_ff <= ST_DONE;
                        end else begin
                           state_ff <= ST_LAUNCH;
                        end
                     end
                     ptwa_pkg::OP_EXPIRE: begin
                        state_ff <= ST_LAUNCH;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_LAUNCH: begin
               state_ff <= ST_PROBE;
            end
            ST_PROBE: begin
               if (tail_probe.valid) begin
                  if (op_ff == ptwa_pkg::OP_EXPIRE) begin
                     state_ff <= ST_COMPACT;
                  end else begin
                     state_ff <= ST_DONE;
                     if (tail_probe.found) begin
                        status_ff <= ptwa_pkg::STS_REFRESHED;
                     end else if (fill_ff < FW'(TABLE_SIZE)) begin
                        status_ff <= ptwa_pkg::STS_ADDED;
                        fill_ff   <= fill_ff + FW'(1);
                     end else begin
                        status_ff <= ptwa_pkg::STS_DROPPED;
                     end
                  end
               end
            end
            ST_COMPACT: begin
               if (front_ff == fill_ff) begin
                  state_ff <= ST_DONE;
               end else if (front_old) begin
                  fill_ff    <= fill_last;
                  expired_ff <= expired_ff + FW'(1);
               end else begin
                  front_ff <= front_ff + FW'(1);
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_data_ff  <= {{PW{1'b0}},
                                   rd_hit ? rd_seen : {NW{1'b0}},
                                   rd_hit ? rd_id   : {DW{1'b0}},
                                   rd_hit,
                                   CW'(fill_ff),
                                   CW'(expired_ff),
                                   status_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // The peer count never runs past the table size.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(TABLE_SIZE))
      else $error("peer count exceeds table size");

   // The compaction front pointer never passes the shrinking count.
   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPACT) |-> (front_ff <= fill_ff))
      else $error("compaction pointer passed the peer count");

   // The peer count does not change while the controller idles without a request.
   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && !req_fire) |=> $stable(fill_ff))
      else $error("peer count changed while idle");

   // A probe only reaches the tail while the controller waits for it.
   a_probe_tail: assert property (@(posedge clock) disable iff (reset)
      tail_probe.valid |-> (state_ff == ST_PROBE))
      else $error("probe left the chain outside the probe phase");
`endif

endmodule
